// File: rtl/graph_dfs_path_search_assert.svh
// Assertion shorthands used by the checker file of the graph search block.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef GRAPH_DFS_PATH_SEARCH_ASSERT_SVH
`define GRAPH_DFS_PATH_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define GDFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GDFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gdfs_pkg.sv
package gdfs_pkg;

  // Node fields on the request and result ports are always this wide.
  localparam int NODE_W = 9;

  localparam int NODE_COUNT_DEF = 512;
  localparam int MAX_DEGREE_DEF = 4;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [1:0] {
    FN_ADD_EDGE    = 2'd0,
    FN_SEARCH      = 2'd1,
    FN_READ_PARENT = 2'd2,
    FN_CLEAR       = 2'd3
  } func_t;

  typedef struct packed {
    func_t func;
    node_t node_a;
    node_t node_b;
  } req_t;

  typedef struct packed {
    logic  found;
    logic  dropped_a;
    logic  dropped_b;
    node_t parent_node;
    logic  parent_valid;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_PAR_RD,
    ST_PAR_WAIT,
    ST_SWEEP,
    ST_START_RD,
    ST_START_WR,
    ST_POP,
    ST_POP_WAIT,
    ST_ROW_WAIT,
    ST_SCAN
  } state_t;

endpackage

// File: rtl/gdfs_ram.sv
module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/graph_dfs_path_search.sv
// An add edge reads and writes back the row of each of its two nodes, a read parent reads
// one row, and a clear graph sweeps every row; an add edge or read parent naming a node
// out of range answers at once. A search sweeps the marks, then marks and pushes the start
// node, then for each node popped waits for its row and checks its neighbours one read at
// a time, through the one read port of the node memory. One request is in flight at a
// time. After rst the node memory is zeroed, one row a cycle, with busy high; the receiver cannot stall.
module graph_dfs_path_search #(
  parameter int NODE_COUNT = gdfs_pkg::NODE_COUNT_DEF,
  parameter int MAX_DEGREE = gdfs_pkg::MAX_DEGREE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  gdfs_pkg::req_t req,
  output logic           done,
  output gdfs_pkg::rsp_t rsp
);

  import gdfs_pkg::*;

  // Internal node index, a counter that can reach NODE_COUNT, and the degree count.
  localparam int AW = $clog2(NODE_COUNT);
  localparam int CW = AW + 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  // Common width used to move between port node numbers and internal indexes.
  localparam int XW = (AW > NODE_W) ? AW : NODE_W;

  typedef logic [AW-1:0] idx_t;
  typedef idx_t [MAX_DEGREE-1:0] nbr_list_t;

  // One row of the node memory holds everything the block knows about a node: its
  // neighbour list with its fill count, and the marks left by the last search.
  typedef struct packed {
    logic [DW-1:0] degree;
    logic          visited;
    logic          has_parent;
    idx_t          parent;
    nbr_list_t     nbr;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic logic in_range(node_t n);
    return 32'(n) < NODE_COUNT;
  endfunction

  function automatic idx_t to_idx(node_t n);
    logic [XW-1:0] w;
    w = XW'(n);
    return w[AW-1:0];
  endfunction

  function automatic node_t to_node(idx_t i);
    logic [XW-1:0] w;
    w = XW'(i);
    return w[NODE_W-1:0];
  endfunction

  // Appends a neighbour to a row whose list is known not to be full.
  function automatic row_t push_nbr(row_t r, idx_t nb);
    row_t o;
    o = r;
    for (int k = 0; k < MAX_DEGREE; k++) begin
      if (DW'(k) == r.degree) begin
        o.nbr[k] = nb;
      end
    end
    o.degree = r.degree + 1'b1;
    return o;
  endfunction

  function automatic idx_t sel_nbr(nbr_list_t l, logic [DW-1:0] s);
    idx_t o;
    o = '0;
    for (int k = 0; k < MAX_DEGREE; k++) begin
      if (DW'(k) == s) begin
        o = l[k];
      end
    end
    return o;
  endfunction

  // Control registers.
  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] sp, sp_next;
  logic          chk_vld, chk_vld_next;
  logic          wr_prev_vld, wr_prev_vld_next;
  logic          done_next;

  // Payload registers.
  req_t          req_q, req_q_next;
  logic          sweep_marks, sweep_marks_next;
  logic          drop_a, drop_a_next;
  idx_t          u_node, u_node_next;
  nbr_list_t     nbr_q, nbr_q_next;
  logic [DW-1:0] deg_q, deg_q_next;
  logic [DW-1:0] slot, slot_next;
  idx_t          chk_node, chk_node_next;
  idx_t          wr_prev_node, wr_prev_node_next;
  rsp_t          rsp_next;

  // Memory ports.
  logic n_we;
  idx_t n_waddr, n_raddr;
  row_t n_wdata, n_rdata;
  logic s_we;
  idx_t s_waddr, s_raddr, s_wdata, s_rdata;

  // Helpers.
  logic [CW-1:0] cnt_m1, sp_m1;
  logic          full_row;
  logic          goal_hit;
  logic          fwd_hit;
  logic          push_ok;
  row_t          row_mod;

  assign cnt_m1   = cnt - 1'b1;
  assign sp_m1    = sp - 1'b1;
  assign full_row = n_rdata.degree >= DW'(MAX_DEGREE);
  assign goal_hit = 32'(s_rdata) == 32'(req_q.node_b);
  // The row of chk_node was read in the same cycle as the previous write, so a write
  // to that same node is not yet in the read data: treat it as already visited.
  assign fwd_hit  = wr_prev_vld && (wr_prev_node == chk_node);
  assign push_ok  = chk_vld && !n_rdata.visited && !fwd_hit && (sp < CW'(NODE_COUNT));

  assign busy = state != ST_IDLE;

  // Node memory: one row per node, read-modify-write through one read and one write port.
  gdfs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  // Search stack. Each node is pushed at most once, so NODE_COUNT entries suffice.
  gdfs_ram #(
    .WIDTH (AW),
    .DEPTH (NODE_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt == CW'(NODE_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (req.func) inside
            FN_ADD_EDGE: begin
              if (in_range(req.node_a) && in_range(req.node_b)) begin
                state_next = ST_ADD_RD_A;
              end
            end
            FN_SEARCH, FN_CLEAR: begin
              state_next = ST_SWEEP;
            end
            FN_READ_PARENT: begin
              if (in_range(req.node_a)) begin
                state_next = ST_PAR_RD;
              end
            end
          endcase
        end
      end
      ST_ADD_RD_A: state_next = ST_ADD_WR_A;
      ST_ADD_WR_A: state_next = ST_ADD_RD_B;
      ST_ADD_RD_B: state_next = ST_ADD_WR_B;
      ST_ADD_WR_B: state_next = ST_IDLE;
      ST_PAR_RD:   state_next = ST_PAR_WAIT;
      ST_PAR_WAIT: state_next = ST_IDLE;
      ST_SWEEP: begin
        if (cnt == CW'(NODE_COUNT)) begin
          state_next = (sweep_marks && in_range(req_q.node_a)) ? ST_START_RD : ST_IDLE;
        end
      end
      ST_START_RD: state_next = ST_START_WR;
      ST_START_WR: state_next = ST_POP;
      ST_POP: begin
        state_next = (sp == '0) ? ST_IDLE : ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        state_next = goal_hit ? ST_IDLE : ST_ROW_WAIT;
      end
      ST_ROW_WAIT: state_next = ST_SCAN;
      ST_SCAN: begin
        if (slot >= deg_q) begin
          state_next = ST_POP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls, datapath and result.
  always_comb begin
    n_we              = 1'b0;
    n_waddr           = '0;
    n_raddr           = '0;
    row_mod           = n_rdata;
    s_we              = 1'b0;
    s_waddr           = sp[AW-1:0];
    s_wdata           = '0;
    s_raddr           = '0;
    cnt_next          = cnt;
    sp_next           = sp;
    chk_vld_next      = chk_vld;
    wr_prev_vld_next  = 1'b0;
    done_next         = 1'b0;
    req_q_next        = req_q;
    sweep_marks_next  = sweep_marks;
    drop_a_next       = drop_a;
    u_node_next       = u_node;
    nbr_q_next        = nbr_q;
    deg_q_next        = deg_q;
    slot_next         = slot;
    chk_node_next     = chk_node;
    wr_prev_node_next = wr_prev_node;
    rsp_next          = rsp;

    unique case (state)
      ST_INIT: begin
        n_we     = 1'b1;
        n_waddr  = cnt[AW-1:0];
        row_mod  = '0;
        cnt_next = cnt + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          req_q_next       = req;
          sweep_marks_next = req.func == FN_SEARCH;
          cnt_next         = '0;
          // An add edge or read parent naming no node answers at once with all zeros.
          if ((req.func == FN_ADD_EDGE &&
               !(in_range(req.node_a) && in_range(req.node_b))) ||
              (req.func == FN_READ_PARENT && !in_range(req.node_a))) begin
            done_next = 1'b1;
            rsp_next  = '0;
          end
        end
      end
      ST_ADD_RD_A: begin
        n_raddr = to_idx(req_q.node_a);
      end
      ST_ADD_WR_A: begin
        drop_a_next = full_row;
        if (!full_row) begin
          n_we    = 1'b1;
          n_waddr = to_idx(req_q.node_a);
          row_mod = push_nbr(n_rdata, to_idx(req_q.node_b));
        end
      end
      ST_ADD_RD_B: begin
        n_raddr = to_idx(req_q.node_b);
      end
      ST_ADD_WR_B: begin
        if (!full_row) begin
          n_we    = 1'b1;
          n_waddr = to_idx(req_q.node_b);
          row_mod = push_nbr(n_rdata, to_idx(req_q.node_a));
        end
        done_next          = 1'b1;
        rsp_next           = '0;
        rsp_next.dropped_a = drop_a;
        rsp_next.dropped_b = full_row;
      end
      ST_PAR_RD: begin
        n_raddr = to_idx(req_q.node_a);
      end
      ST_PAR_WAIT: begin
        done_next             = 1'b1;
        rsp_next              = '0;
        rsp_next.parent_valid = n_rdata.has_parent;
        if (n_rdata.has_parent) begin
          rsp_next.parent_node = to_node(n_rdata.parent);
        end
      end
      ST_SWEEP: begin
        // Row cnt is read while row cnt-1, read in the cycle before, is written back.
        if (cnt < CW'(NODE_COUNT)) begin
          n_raddr = cnt[AW-1:0];
        end
        if (cnt != '0) begin
          n_we    = 1'b1;
          n_waddr = cnt_m1[AW-1:0];
          if (sweep_marks) begin
            row_mod.visited    = 1'b0;
            row_mod.has_parent = 1'b0;
          end else begin
            row_mod.degree = '0;
          end
        end
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(NODE_COUNT)) begin
          sp_next = '0;
          if (!(sweep_marks && in_range(req_q.node_a))) begin
            done_next = 1'b1;
            rsp_next  = '0;
          end
        end
      end
      ST_START_RD: begin
        n_raddr = to_idx(req_q.node_a);
      end
      ST_START_WR: begin
        n_we            = 1'b1;
        n_waddr         = to_idx(req_q.node_a);
        row_mod.visited = 1'b1;
        s_we            = 1'b1;
        s_waddr         = '0;
        s_wdata         = to_idx(req_q.node_a);
        sp_next         = CW'(1);
      end
      ST_POP: begin
        if (sp != '0) begin
          s_raddr = sp_m1[AW-1:0];
          sp_next = sp_m1;
        end else begin
          done_next = 1'b1;
          rsp_next  = '0;
        end
      end
      ST_POP_WAIT: begin
        u_node_next = s_rdata;
        n_raddr     = s_rdata;
        if (goal_hit) begin
          done_next      = 1'b1;
          rsp_next       = '0;
          rsp_next.found = 1'b1;
        end
      end
      ST_ROW_WAIT: begin
        deg_q_next       = n_rdata.degree;
        nbr_q_next       = n_rdata.nbr;
        slot_next        = '0;
        chk_vld_next     = 1'b0;
      end
      ST_SCAN: begin
        // Check the neighbour whose row arrives now, and issue the read of the next one.
        if (push_ok) begin
          n_we               = 1'b1;
          n_waddr            = chk_node;
          row_mod.visited    = 1'b1;
          row_mod.has_parent = 1'b1;
          row_mod.parent     = u_node;
          s_we               = 1'b1;
          s_waddr            = sp[AW-1:0];
          s_wdata            = chk_node;
          sp_next            = sp + 1'b1;
          wr_prev_vld_next   = 1'b1;
          wr_prev_node_next  = chk_node;
        end
        if (slot < deg_q) begin
          n_raddr       = sel_nbr(nbr_q, slot);
          chk_vld_next  = 1'b1;
          chk_node_next = sel_nbr(nbr_q, slot);
          slot_next     = slot + 1'b1;
        end else begin
          chk_vld_next = 1'b0;
        end
      end
      default: begin
        n_we = 1'b0;
      end
    endcase
    n_wdata = row_mod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cnt         <= '0;
      sp          <= '0;
      chk_vld     <= 1'b0;
      wr_prev_vld <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      sp          <= sp_next;
      chk_vld     <= chk_vld_next;
      wr_prev_vld <= wr_prev_vld_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q        <= req_q_next;
    sweep_marks  <= sweep_marks_next;
    drop_a       <= drop_a_next;
    u_node       <= u_node_next;
    nbr_q        <= nbr_q_next;
    deg_q        <= deg_q_next;
    slot         <= slot_next;
    chk_node     <= chk_node_next;
    wr_prev_node <= wr_prev_node_next;
    rsp          <= rsp_next;
  end

endmodule

// File: rtl/gdfs_checker.sv
`include "graph_dfs_path_search_assert.svh"

module gdfs_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input gdfs_pkg::req_t req,
  input logic           done,
  input gdfs_pkg::rsp_t rsp
);

  import gdfs_pkg::*;

  logic accepted;
  logic long_req;
  logic no_parent;
  logic drop_seen;

  assign accepted  = start && !busy;
  assign long_req  = (req.func == FN_SEARCH) || (req.func == FN_CLEAR);
  assign no_parent = done && !rsp.parent_valid;
  assign drop_seen = done && (rsp.dropped_a || rsp.dropped_b);

  // A result is only given once the block is ready for the next request.
  `GDFS_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")

  // Busy rises only from an accepted request or out of reset.
  `GDFS_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start) || $past(rst), "busy without request")

  // Search and clear always sweep the node memory, so they never answer at once.
  `GDFS_ASSERT_NXT(a_sweep_busy, accepted && long_req, busy && !done, "sweep answered at once")

  // A parent node is only reported together with its valid flag.
  `GDFS_ASSERT_IMP(a_parent_zero, no_parent, rsp.parent_node == '0, "parent without valid")

  // Drop flags belong to add edge alone.
  `GDFS_ASSERT_IMP(a_flags_excl, drop_seen, !rsp.found && !rsp.parent_valid, "mixed result flags")

endmodule

bind graph_dfs_path_search gdfs_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
